[hdl/itoa_pkg.sv]
// Shared types, constants and the digit-to-character map for the radix converter.
// Depends on nothing; every other file in the project but itoa_ram uses it.
`timescale 1ns / 1ps

package itoa_pkg;

   // Field widths of the channels.
   localparam int unsigned RADIX_W = 5;
   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned DIGIT_W = 4;

   // Dividend bits retired by one pass of the divide step.
   localparam int unsigned STEP_BITS = 8;

   // Width of the sequencer's step address.
   localparam int unsigned PC_W = 4;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

   localparam logic [DIGIT_W-1:0] DEC_DIGITS = 4'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

   // Datapath operation carried by one control word.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_MINUS,
      OP_DIV,
      OP_STORE,
      OP_READ,
      OP_EMIT
   } op_type;

   // Jump condition carried by one control word.
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_BAD_RADIX,
      C_NOT_NEG10,
      C_CHUNK_MORE,
      C_Q_NONZERO,
      C_MORE_DIGITS
   } cond_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type   op;
      logic     wait_out;
      cond_type cond;
      pc_type   target;
   } ctrl_word_type;

   // Status the datapath reports back to the sequencer.
   typedef struct packed {
      logic req_valid;
      logic bad_radix;
      logic neg10;
      logic chunk_more;
      logic q_nonzero;
      logic more_digits;
   } flags_type;

   // Upper-case hexadecimal character for one digit.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < DEC_DIGITS) begin
         digit_char = CHAR_ZERO + d_ext;
      end else begin
         digit_char = CHAR_A + d_ext - CHAR_W'(DEC_DIGITS);
      end
   endfunction

endpackage

[hdl/itoa_if.sv]
// Valid/ready channel interfaces for the request and response sides of the converter.
// Depends on itoa_pkg for the field widths.
`timescale 1ns / 1ps

interface itoa_req_if #(
   parameter int unsigned VALUE_BITS = 32
) ();
   logic                              valid;
   logic                              ready;
   logic signed [VALUE_BITS-1:0]      value;
   logic [itoa_pkg::RADIX_W-1:0]      radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itoa_rsp_if ();
   logic                              valid;
   logic                              ready;
   logic [itoa_pkg::CHAR_W-1:0]       ascii_char;
   logic                              last;

   modport source (output valid, output ascii_char, output last, input ready);
   modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

[hdl/itoa_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module itoa_ram #(
   parameter int unsigned WIDTH = 4,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/itoa_seq.sv]
// Microcode sequencer: step counter, control-word table and conditional jumps.
// Depends on itoa_pkg for the control word and status types.
`timescale 1ns / 1ps

module itoa_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  itoa_pkg::flags_type     flags,
   input  logic                    out_free,
   output itoa_pkg::ctrl_word_type ctrl,
   output logic                    go
);
   import itoa_pkg::*;

   localparam pc_type STEP_WAIT  = 4'd0;
   localparam pc_type STEP_CHECK = 4'd1;
   localparam pc_type STEP_SIGN  = 4'd2;
   localparam pc_type STEP_MINUS = 4'd3;
   localparam pc_type STEP_DIV   = 4'd4;
   localparam pc_type STEP_STORE = 4'd5;
   localparam pc_type STEP_READ  = 4'd6;
   localparam pc_type STEP_EMIT  = 4'd7;
   localparam pc_type STEP_DONE  = 4'd8;

   // The program. A word jumps to its target when its condition holds,
   // otherwise it falls through to the next step.
   function automatic ctrl_word_type program_word(input pc_type addr);
      ctrl_word_type w;
      case (addr)
         STEP_WAIT:  w = '{op: OP_LOAD,  wait_out: 1'b0, cond: C_NO_REQ,      target: STEP_WAIT};
         STEP_CHECK: w = '{op: OP_NONE,  wait_out: 1'b0, cond: C_BAD_RADIX,   target: STEP_WAIT};
         STEP_SIGN:  w = '{op: OP_NONE,  wait_out: 1'b0, cond: C_NOT_NEG10,   target: STEP_DIV};
         STEP_MINUS: w = '{op: OP_MINUS, wait_out: 1'b1, cond: C_NEVER,       target: STEP_WAIT};
         STEP_DIV:   w = '{op: OP_DIV,   wait_out: 1'b0, cond: C_CHUNK_MORE,  target: STEP_DIV};
         STEP_STORE: w = '{op: OP_STORE, wait_out: 1'b0, cond: C_Q_NONZERO,   target: STEP_DIV};
         STEP_READ:  w = '{op: OP_READ,  wait_out: 1'b0, cond: C_NEVER,       target: STEP_WAIT};
         STEP_EMIT:  w = '{op: OP_EMIT,  wait_out: 1'b1, cond: C_MORE_DIGITS, target: STEP_READ};
         STEP_DONE:  w = '{op: OP_NONE,  wait_out: 1'b0, cond: C_ALWAYS,      target: STEP_WAIT};
         default:    w = '{op: OP_NONE,  wait_out: 1'b0, cond: C_ALWAYS,      target: STEP_WAIT};
      endcase
      return w;
   endfunction

   pc_type pc_ff;
   pc_type pc_in;
   logic   taken;

   assign ctrl = program_word(pc_ff);

   // A step that drives the response register holds until that register is free.
   assign go = !(ctrl.wait_out && !out_free);

   // Jump condition of the current word.
   always_comb begin
      case (ctrl.cond)
         C_NEVER:       taken = 1'b0;
         C_ALWAYS:      taken = 1'b1;
         C_NO_REQ:      taken = !flags.req_valid;
         C_BAD_RADIX:   taken = flags.bad_radix;
         C_NOT_NEG10:   taken = !flags.neg10;
         C_CHUNK_MORE:  taken = flags.chunk_more;
         C_Q_NONZERO:   taken = flags.q_nonzero;
         C_MORE_DIGITS: taken = flags.more_digits;
         default:       taken = 1'b0;
      endcase
   end

   // Next step address.
   always_comb begin
      if (!go) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[hdl/integer_to_ascii_radix.sv]
// Top level of the integer-to-ASCII radix converter: datapath, digit RAM and response register.
// Depends on itoa_pkg, itoa_if, itoa_ram and itoa_seq.
//
//   Channel | Direction | Payload               | Transfer when
//   --------+-----------+-----------------------+---------------------------
//   req     | in        | value, radix          | req.valid && req.ready
//   rsp     | out       | ascii_char, last      | rsp.valid && rsp.ready
//
// One item passes the setup steps (load, radix check, sign check), a step for a leading minus sign
// on a negative decimal value, then per digit CHUNKS passes of the shared divide step (8 dividend
// bits a cycle, CHUNKS = ceil(VALUE_BITS / 8)) and a store; then per digit a read of the digit RAM
// and a send step, and a closing step.
// Reset is synchronous and leaves the sequencer waiting with no response pending.
// A stalled response only holds the send steps; a new request is taken while the
// final character of the previous one still waits in the response register.
`timescale 1ns / 1ps

module integer_to_ascii_radix #(
   parameter int unsigned VALUE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   itoa_req_if.sink   req,
   itoa_rsp_if.source rsp
);
   import itoa_pkg::*;

   localparam int unsigned CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int unsigned PAD_BITS = CHUNKS * STEP_BITS;
   localparam int unsigned CHUNK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int unsigned ADDR_W   = $clog2(VALUE_BITS);
   localparam int unsigned CNT_W    = $clog2(VALUE_BITS + 1);

   ctrl_word_type ctrl;
   flags_type     flags;
   logic          go;
   logic          out_free;

   logic [PAD_BITS-1:0]   val_ff, val_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [CHUNK_W-1:0]    chunk_ff, chunk_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      cnt_dec;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   logic [VALUE_BITS-1:0] value_raw;
   logic [VALUE_BITS-1:0] value_neg;
   logic [DIGIT_W-1:0]    div_rem;
   logic [STEP_BITS-1:0]  div_quot;
   logic [RADIX_W-1:0]    div_trial;
   logic [RADIX_W-1:0]    div_diff;
   logic [DIGIT_W-1:0]    ram_rd_data;

   itoa_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .flags    (flags),
      .out_free (out_free),
      .ctrl     (ctrl),
      .go       (go)
   );

   itoa_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (VALUE_BITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (go && (ctrl.op == OP_STORE)),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (rem_ff),
      .rd_en   (ctrl.op == OP_READ),
      .rd_addr (cnt_dec[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req.ready = (ctrl.op == OP_LOAD);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign cnt_dec   = cnt_ff - 1'b1;
   assign value_raw = req.value;
   assign value_neg = VALUE_BITS'(0) - val_ff[VALUE_BITS-1:0];

   // Status for the sequencer's jump conditions.
   always_comb begin
      flags.req_valid   = req.valid;
      flags.bad_radix   = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);
      flags.neg10       = (radix_ff == RADIX_DEC) && val_ff[VALUE_BITS-1];
      flags.chunk_more  = (chunk_ff != CHUNK_W'(CHUNKS - 1));
      flags.q_nonzero   = (val_ff != '0);
      flags.more_digits = (cnt_ff != '0);
   end

   // One divide pass: restoring division of the top dividend bits by the radix,
   // one bit per stage. The partial remainder always stays below the radix.
   always_comb begin
      div_rem   = rem_ff;
      div_quot  = '0;
      div_trial = '0;
      div_diff  = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         div_trial = {div_rem, val_ff[PAD_BITS-1-i]};
         div_diff  = div_trial - radix_ff;
         if (div_trial >= radix_ff) begin
            div_rem                 = div_diff[DIGIT_W-1:0];
            div_quot[STEP_BITS-1-i] = 1'b1;
         end else begin
            div_rem = div_trial[DIGIT_W-1:0];
         end
      end
   end

   // Datapath registers driven by the current control word.
   always_comb begin
      val_in   = val_ff;
      radix_in = radix_ff;
      rem_in   = rem_ff;
      chunk_in = chunk_ff;
      cnt_in   = cnt_ff;
      case (ctrl.op)
         OP_LOAD: begin
            val_in   = PAD_BITS'(value_raw);
            radix_in = req.radix;
            rem_in   = '0;
            chunk_in = '0;
            cnt_in   = '0;
         end
         OP_MINUS: begin
            if (go) begin
               val_in = PAD_BITS'(value_neg);
            end
         end
         OP_DIV: begin
            val_in   = (val_ff << STEP_BITS) | PAD_BITS'(div_quot);
            rem_in   = div_rem;
            chunk_in = flags.chunk_more ? chunk_ff + 1'b1 : '0;
         end
         OP_STORE: begin
            rem_in = '0;
            cnt_in = cnt_ff + 1'b1;
         end
         OP_READ: begin
            cnt_in = cnt_dec;
         end
         default: begin
         end
      endcase
   end

   // Response register: loaded by the sign and send steps, drained by a transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      if (go && (ctrl.op == OP_MINUS)) begin
         rsp_valid_in = 1'b1;
         char_in      = CHAR_MINUS;
         last_in      = 1'b0;
      end else if (go && (ctrl.op == OP_EMIT)) begin
         rsp_valid_in = 1'b1;
         char_in      = digit_char(ram_rd_data);
         last_in      = (cnt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         chunk_ff     <= '0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         chunk_ff     <= chunk_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      radix_ff <= radix_in;
      rem_ff   <= rem_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.ascii_char = char_ff;
   assign rsp.last       = last_ff;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for integer_to_ascii_radix: directed corner values, then random traffic.
// Depends on itoa_pkg, the itoa_if channel interfaces and the converter RTL; reads no files.
`timescale 1ns / 1ps

module tb_top;
   import itoa_pkg::*;

   localparam int unsigned VALUE_BITS  = 32;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned SETTLE_CYCLES = 300;
   localparam int unsigned HOLD_OFF_CYCLES = 400;

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [RADIX_W-1:0] radix_type;

   // One character of a converted number as it leaves the block.
   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last;
   } char_beat_type;

   logic clock;
   logic reset;

   itoa_req_if #(.VALUE_BITS(VALUE_BITS)) req_bus ();
   itoa_rsp_if rsp_bus ();

   integer_to_ascii_radix #(.VALUE_BITS(VALUE_BITS)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   char_beat_type expected_chars[$];
   string         digit_set = "0123456789ABCDEF";

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int error_count = 0;
   int numbers_sent = 0;
   int ignored_sent = 0;
   int chars_checked = 0;
   int cycle_count = 0;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Expected character run for one number in one base.
   function automatic void predict_digits(input value_type value, input radix_type radix);
      logic [VALUE_BITS-1:0] mag;
      logic [VALUE_BITS-1:0] base_v;
      logic [3:0]            digits[$];
      char_beat_type         beat;
      if (radix < RADIX_MIN || radix > RADIX_MAX) begin
         return;
      end
      mag    = value;
      base_v = VALUE_BITS'(radix);
      // Decimal prints a sign and the magnitude; the most negative value wraps to itself.
      if (radix == RADIX_DEC && mag[VALUE_BITS-1]) begin
         beat.ascii_char = CHAR_MINUS;
         beat.last       = 1'b0;
         expected_chars.push_back(beat);
         mag = -mag;
      end
      if (mag == '0) begin
         beat.ascii_char = CHAR_ZERO;
         beat.last       = 1'b1;
         expected_chars.push_back(beat);
         return;
      end
      while (mag != '0) begin
         digits.push_front(4'(mag % base_v));
         mag = mag / base_v;
      end
      foreach (digits[i]) begin
         beat.ascii_char = digit_set[digits[i]];
         beat.last       = (i == digits.size() - 1);
         expected_chars.push_back(beat);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // Offers one number; entered and left just after a falling edge.
   task automatic send_number(input value_type value, input radix_type radix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.value = value;
      req_bus.radix = radix;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      predict_digits(value, radix);
      if (radix < RADIX_MIN || radix > RADIX_MAX) begin
         ignored_sent++;
      end else begin
         numbers_sent++;
      end
      @(negedge clock);
   endtask

   // Sender stops offering until every expected character has been seen.
   task automatic wait_for_results();
      req_bus.valid = 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Random number with weight on small magnitudes and the extremes.
   function automatic value_type random_value();
      case ($urandom_range(5))
         0, 1: random_value = value_type'($urandom);
         2: random_value = value_type'($urandom_range(300));
         3: random_value = -value_type'($urandom_range(1, 300));
         4: random_value = value_type'(32'h1 << $urandom_range(31)) -
                           value_type'($urandom_range(1));
         default: begin
            case ($urandom_range(3))
               0: random_value = '0;
               1: random_value = value_type'(32'h8000_0000);
               2: random_value = value_type'(32'h7FFF_FFFF);
               default: random_value = -1;
            endcase
         end
      endcase
   endfunction

   // Mostly legal bases, with some that the block must drop.
   function automatic radix_type random_radix();
      if ($urandom_range(99) < 12) begin
         if ($urandom_range(1) == 0) begin
            random_radix = radix_type'($urandom_range(1));
         end else begin
            random_radix = radix_type'($urandom_range(17, 31));
         end
      end else begin
         random_radix = radix_type'($urandom_range(2, 16));
      end
   endfunction

   // Zero, sign handling, the most negative value, extreme bases and dropped bases.
   task automatic test_special_cases();
      send_idle_pct = 14;
      recv_idle_pct = 56;
      send_number(0, 10);
      send_number(0, 2);
      send_number(0, 16);
      send_number(1, 2);
      send_number(-1, 10);
      send_number(-1, 2);
      send_number(-1, 16);
      send_number(value_type'(32'h8000_0000), 10);
      send_number(value_type'(32'h8000_0000), 16);
      send_number(value_type'(32'h8000_0000), 2);
      send_number(value_type'(32'h7FFF_FFFF), 10);
      send_number(value_type'(32'h7FFF_FFFF), 2);
      send_number(10, 10);
      send_number(255, 16);
      send_number(15, 15);
      send_number(12345, 3);
      send_number(-123456789, 8);
      send_number(-1234567890, 10);
      send_number(42, 0);
      send_number(42, 1);
      send_number(42, 17);
      send_number(-1, 31);
      send_number(7, 16);
      wait_for_results();
   endtask

   // Random traffic under one idle pattern; count covers legal bases only.
   task automatic test_random_phase(input int count, input int s_idle, input int r_idle);
      int legal_before;
      legal_before  = numbers_sent;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      while (numbers_sent - legal_before < count) begin
         send_number(random_value(), random_radix());
         if ($urandom_range(49) == 0) begin
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   // Receiver holds off long enough for the block to stall its input.
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      repeat (12) begin
         send_number(value_type'($urandom), radix_type'($urandom_range(2, 16)));
      end
      wait_for_results();
   endtask

   // Response ready, with a long hold-off on request from the test sequence.
   initial begin : drive_rsp_ready
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Each character transfer is compared with the oldest expectation.
   always @(posedge clock) begin : check_chars
      char_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last %b",
                                      rsp_bus.ascii_char, rsp_bus.last));
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_bus.ascii_char !== want.ascii_char) begin
               report_mismatch($sformatf("ascii_char 0x%02h, expected 0x%02h ('%c')",
                                         rsp_bus.ascii_char, want.ascii_char,
                                         want.ascii_char));
            end
            if (rsp_bus.last !== want.last) begin
               report_mismatch($sformatf("last %b, expected %b on '%c'",
                                         rsp_bus.last, want.last, want.ascii_char));
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d chars outstanding",
                  cycle_count, expected_chars.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      req_bus.radix = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_special_cases();
      test_random_phase(85, 14, 56);
      test_output_stall();
      test_random_phase(85, 56, 14);
      test_random_phase(85, 0, 0);

      req_bus.valid = 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Converted %0d numbers in bases 2 to 16 plus %0d with dropped bases,",
               numbers_sent, ignored_sent);
      $display("checking %0d characters under mixed idling and a long output stall.",
               chars_checked);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/itoa_pkg.sv
hdl/itoa_if.sv
hdl/itoa_ram.sv
hdl/itoa_seq.sv
hdl/integer_to_ascii_radix.sv
dv/tb_top.sv
